### rtl/sks_pkg.sv
// Shared types and constants of the scalar Kalman smoother.
package sks_pkg;

    // Field and register widths
    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned EST_W      = 28;
    localparam int unsigned ERR_W      = 32;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned NOISE_W    = 16;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Shared multiplier: 32 x 17 bits
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = GAIN_W + 1;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MEASURE_ERROR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROCESS_NOISE = 2'd1;

    // Reset values
    localparam logic [ERR_W-1:0]   MEASURE_ERROR_RST = 32'd131072;
    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 16'd655;
    localparam logic [ERR_W-1:0]   EST_ERROR_RST     = 32'd131072;

    // Rounding constant and 1.0 in Q16
    localparam logic [PROD_W-1:0]   HALF_LSB = PROD_W'(32768);
    localparam logic [MUL_B_W-1:0]  ONE_Q16  = MUL_B_W'(65536);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_STEP,
        ST_MUL_KEEP,
        ST_MUL_NOISE,
        ST_FINISH
    } sks_state_t;

endpackage

### rtl/sks_cfg_if.sv
// Configuration write channel: register index and write data.
interface sks_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sks_pkg::CFG_ADDR_W-1:0]     index;
    logic [sks_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sks_sample_if.sv
// Input channel carrying one raw sample word.
interface sks_sample_if;
    logic                           valid;
    logic                           ready;
    logic [sks_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

### rtl/sks_estimate_if.sv
// Output channel carrying one smoothed estimate word.
interface sks_estimate_if;
    logic                       valid;
    logic                       ready;
    logic [sks_pkg::EST_W-1:0]  estimate;

    modport source (output valid, estimate, input ready);
    modport sink   (input valid, estimate, output ready);
endinterface

### rtl/scalar_kalman_smoother.sv
// From sample accept to estimate valid: 16 divider steps, 3 multiplies and 1 finish step,
// run on the radix-2 gain divider and one shared 32x17 multiplier. No new sample is taken
// until the finish step is done. A held estimate word stalls only
// the finish step. Reset (rst_n low, asynchronous) restores R = 2.0, Q = 655/65536,
// estimate 0 and error 2.0; no clearing pass is needed.
module scalar_kalman_smoother
(
    input  logic                    clk,
    input  logic                    rst_n,
    sks_cfg_if.sink                 cfg,
    sks_sample_if.sink              samples,
    sks_estimate_if.source          estimates
);

    sks_pkg::sks_state_t state_reg, state_next;

    logic [sks_pkg::ERR_W-1:0]      measure_error_reg;
    logic [sks_pkg::NOISE_W-1:0]    process_noise_reg;
    logic [sks_pkg::EST_W-1:0]      prior_estimate_reg;
    logic [sks_pkg::ERR_W-1:0]      estimate_error_reg;

    logic [sks_pkg::EST_W-1:0]      diff_reg;
    logic                           up_reg;
    logic [sks_pkg::ERR_W:0]        denom_reg;
    logic [sks_pkg::ERR_W:0]        rem_reg;
    logic [sks_pkg::GAIN_W-1:0]     gain_reg;
    logic [3:0]                     div_cnt_reg;
    logic [sks_pkg::PROD_W-1:0]     prod_reg;
    logic [sks_pkg::EST_W-1:0]      step_reg;
    logic [sks_pkg::ERR_W:0]        keep_reg;

    logic                           out_valid_reg;
    logic [sks_pkg::EST_W-1:0]      out_est_reg;

    logic                           in_accept;
    logic                           out_free;
    logic [sks_pkg::EST_W-1:0]      meas;
    logic [sks_pkg::ERR_W-1:0]      r_eff;
    logic [sks_pkg::ERR_W+1:0]      rem_sh;
    logic                           q_bit;
    logic [sks_pkg::MUL_A_W-1:0]    mul_a;
    logic [sks_pkg::MUL_B_W-1:0]    mul_b;
    logic [sks_pkg::PROD_W-1:0]     prod_rnd;
    logic [sks_pkg::ERR_W:0]        rnd_hi;
    logic [sks_pkg::EST_W-1:0]      step_clamped;
    logic [sks_pkg::ERR_W+1:0]      err_sum;
    logic [sks_pkg::ERR_W-1:0]      err_new;
    logic [sks_pkg::EST_W-1:0]      est_new;

    // Handshakes
    assign cfg.ready         = 1'b1;
    assign samples.ready     = (state_reg == sks_pkg::ST_IDLE);
    assign in_accept         = samples.valid && samples.ready;
    assign out_free          = !out_valid_reg || estimates.ready;
    assign estimates.valid   = out_valid_reg;
    assign estimates.estimate = out_est_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sks_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = sks_pkg::ST_DIV;
                end
            end
            sks_pkg::ST_DIV:
            begin
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = sks_pkg::ST_MUL_STEP;
                end
            end
            sks_pkg::ST_MUL_STEP:  state_next = sks_pkg::ST_MUL_KEEP;
            sks_pkg::ST_MUL_KEEP:  state_next = sks_pkg::ST_MUL_NOISE;
            sks_pkg::ST_MUL_NOISE: state_next = sks_pkg::ST_FINISH;
            sks_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = sks_pkg::ST_IDLE;
                end
            end
            default: state_next = sks_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            sks_pkg::ST_MUL_STEP:
            begin
                mul_a = sks_pkg::MUL_A_W'(diff_reg);
                mul_b = {1'b0, gain_reg};
            end
            sks_pkg::ST_MUL_KEEP:
            begin
                mul_a = estimate_error_reg;
                mul_b = sks_pkg::ONE_Q16 - {1'b0, gain_reg};
            end
            sks_pkg::ST_MUL_NOISE:
            begin
                mul_a = sks_pkg::MUL_A_W'(step_reg);
                mul_b = {1'b0, process_noise_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Datapath helpers
    assign meas   = {samples.sample, {sks_pkg::FRAC_W{1'b0}}};
    assign r_eff  = (measure_error_reg == '0) ? sks_pkg::ERR_W'(1) : measure_error_reg;
    assign rem_sh = {rem_reg, 1'b0};
    assign q_bit  = (rem_sh >= {1'b0, denom_reg});

    // Round the registered product back to the integer grid of its operand
    assign prod_rnd = prod_reg + sks_pkg::HALF_LSB;
    assign rnd_hi   = prod_rnd[sks_pkg::PROD_W-1:sks_pkg::FRAC_W];
    assign step_clamped = (rnd_hi > {5'd0, diff_reg}) ? diff_reg
                                                      : rnd_hi[sks_pkg::EST_W-1:0];

    // New error: keep term plus noise term, saturated
    assign err_sum = {1'b0, keep_reg} + {1'b0, rnd_hi};
    assign err_new = (err_sum[sks_pkg::ERR_W+1:sks_pkg::ERR_W] != 2'd0)
                     ? {sks_pkg::ERR_W{1'b1}} : err_sum[sks_pkg::ERR_W-1:0];
    assign est_new = up_reg ? (prior_estimate_reg + step_reg)
                            : (prior_estimate_reg - step_reg);

    // Control state and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= sks_pkg::ST_IDLE;
            div_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
            measure_error_reg  <= sks_pkg::MEASURE_ERROR_RST;
            process_noise_reg  <= sks_pkg::PROCESS_NOISE_RST;
            prior_estimate_reg <= '0;
            estimate_error_reg <= sks_pkg::EST_ERROR_RST;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    sks_pkg::CFG_MEASURE_ERROR: measure_error_reg <= cfg.data;
                    sks_pkg::CFG_PROCESS_NOISE:
                        process_noise_reg <= cfg.data[sks_pkg::NOISE_W-1:0];
                    default: ;
                endcase
            end

            // Divider step count
            if (in_accept)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == sks_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end

            // Drop the output word once taken, load a new one at finish
            if ((state_reg == sks_pkg::ST_FINISH) && out_free)
            begin
                out_valid_reg      <= 1'b1;
                prior_estimate_reg <= est_new;
                estimate_error_reg <= err_new;
            end
            else if (estimates.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            up_reg    <= (meas >= prior_estimate_reg);
            diff_reg  <= (meas >= prior_estimate_reg) ? (meas - prior_estimate_reg)
                                                      : (prior_estimate_reg - meas);
            denom_reg <= {1'b0, estimate_error_reg} + {1'b0, r_eff};
            rem_reg   <= {1'b0, estimate_error_reg};
        end

        // One restoring division step per cycle
        if (state_reg == sks_pkg::ST_DIV)
        begin
            gain_reg <= {gain_reg[sks_pkg::GAIN_W-2:0], q_bit};
            rem_reg  <= q_bit ? (sks_pkg::ERR_W+1)'(rem_sh - {1'b0, denom_reg})
                              : rem_sh[sks_pkg::ERR_W:0];
        end

        // Shared multiplier, registered
        if ((state_reg == sks_pkg::ST_MUL_STEP) || (state_reg == sks_pkg::ST_MUL_KEEP) ||
            (state_reg == sks_pkg::ST_MUL_NOISE))
        begin
            prod_reg <= mul_a * mul_b;
        end

        if (state_reg == sks_pkg::ST_MUL_KEEP)
        begin
            step_reg <= step_clamped;
        end
        if (state_reg == sks_pkg::ST_MUL_NOISE)
        begin
            keep_reg <= rnd_hi;
        end

        if ((state_reg == sks_pkg::ST_FINISH) && out_free)
        begin
            out_est_reg <= est_new;
        end
    end

endmodule

### rtl/sks_checker.sv
// Port-level assertions for the scalar Kalman smoother, bound to the top level.
module sks_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [sks_pkg::EST_W-1:0]    estimate
);

    // Stay busy after taking a sample word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("sample taken while previous one still in work");

    // A new estimate word only leaves the finish step, never idle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> !$past(in_ready))
        else $error("estimate word appeared without a sample in work");

    // Hold a stalled estimate word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(estimate)))
        else $error("stalled estimate word changed or dropped");

endmodule

bind scalar_kalman_smoother sks_checker u_sks_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (estimates.valid),
    .out_ready (estimates.ready),
    .estimate  (estimates.estimate)
);
